### hw/rtl/ial_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_pkg: shared definitions for the indexed array list
// Widths, command and status codes, controller states and the command and
// status structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ial_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WRITE,
      S_UP_RD,
      S_UP_WR,
      S_DN_RD,
      S_DN_WR,
      S_RD,
      S_RD_CAP,
      S_FIRST,
      S_LAST,
      S_LAST_CAP,
      S_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      PTR_COUNT,
      PTR_COUNT_M1,
      PTR_POS
   } ptr_sel_type;

   typedef enum logic [2:0] {
      RA_PTR,
      RA_PTR_M1,
      RA_PTR_P1,
      RA_ZERO,
      RA_LAST
   } raddr_sel_type;

   typedef enum logic {
      WD_VALUE,
      WD_READ
   } wdata_sel_type;

   typedef struct packed {
      logic                load_req;
      logic                clr_result;
      logic                ptr_load;
      ptr_sel_type         ptr_sel;
      logic                ptr_inc;
      logic                ptr_dec;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                rd_en;
      raddr_sel_type       ra_sel;
      logic                wr_en;
      wdata_sel_type       wd_sel;
      logic                cap_read;
      logic                cap_first;
      logic                cap_last;
      logic                set_status;
      logic [STATUS_W-1:0] status;
   } ctrl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             empty;
      logic             pos_ok;
      logic             ptr_at_pos;
      logic             ptr_at_tail;
   } stat_type;

endpackage

### hw/rtl/ial_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_ctrl: command sequencer of the indexed array list
// Decodes each command, steps the datapath through its reads, writes and
// shifts one memory access at a time, and then issues the result beat.
// ----------------------------------------------------------------------------
module ial_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output ial_pkg::ctrl_type ctrl,
   input  ial_pkg::stat_type stat
);

   ial_pkg::state_type state_ff;
   ial_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ial_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ial_pkg::S_IDLE: begin
            if (start) begin
               state_in = ial_pkg::S_DECODE;
            end
         end
         ial_pkg::S_DECODE: begin
            state_in = ial_pkg::S_FIRST;
            unique case (stat.cmd)
               ial_pkg::CMD_PUSH: begin
                  if (!stat.full) begin
                     state_in = ial_pkg::S_WRITE;
                  end
               end
               ial_pkg::CMD_POP: begin
                  if (!stat.empty) begin
                     state_in = ial_pkg::S_RD;
                  end
               end
               ial_pkg::CMD_INSERT: begin
                  if (stat.pos_ok && !stat.full) begin
                     state_in = ial_pkg::S_UP_RD;
                  end
               end
               ial_pkg::CMD_ERASE: begin
                  if (stat.pos_ok) begin
                     state_in = ial_pkg::S_DN_RD;
                  end
               end
               ial_pkg::CMD_READ: begin
                  if (stat.pos_ok) begin
                     state_in = ial_pkg::S_RD;
                  end
               end
               default: begin
                  state_in = ial_pkg::S_FIRST;
               end
            endcase
         end
         ial_pkg::S_WRITE: begin
            state_in = ial_pkg::S_FIRST;
         end
         ial_pkg::S_UP_RD: begin
            if (stat.ptr_at_pos) begin
               state_in = ial_pkg::S_WRITE;
            end else begin
               state_in = ial_pkg::S_UP_WR;
            end
         end
         ial_pkg::S_UP_WR: begin
            state_in = ial_pkg::S_UP_RD;
         end
         ial_pkg::S_DN_RD: begin
            if (stat.ptr_at_tail) begin
               state_in = ial_pkg::S_FIRST;
            end else begin
               state_in = ial_pkg::S_DN_WR;
            end
         end
         ial_pkg::S_DN_WR: begin
            state_in = ial_pkg::S_DN_RD;
         end
         ial_pkg::S_RD: begin
            state_in = ial_pkg::S_RD_CAP;
         end
         ial_pkg::S_RD_CAP: begin
            state_in = ial_pkg::S_FIRST;
         end
         ial_pkg::S_FIRST: begin
            state_in = ial_pkg::S_LAST;
         end
         ial_pkg::S_LAST: begin
            state_in = ial_pkg::S_LAST_CAP;
         end
         ial_pkg::S_LAST_CAP: begin
            state_in = ial_pkg::S_RESPOND;
         end
         ial_pkg::S_RESPOND: begin
            state_in = ial_pkg::S_IDLE;
         end
         default: begin
            state_in = ial_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl            = '0;
      ctrl.ptr_sel    = ial_pkg::PTR_COUNT;
      ctrl.ra_sel     = ial_pkg::RA_PTR;
      ctrl.wd_sel     = ial_pkg::WD_VALUE;
      ctrl.status     = ial_pkg::ST_OK;
      busy            = (state_ff != ial_pkg::S_IDLE);
      rsp_valid       = 1'b0;
      unique case (state_ff)
         ial_pkg::S_IDLE: begin
            if (start) begin
               ctrl.load_req   = 1'b1;
               ctrl.clr_result = 1'b1;
            end
         end
         ial_pkg::S_DECODE: begin
            unique case (stat.cmd) inside
               ial_pkg::CMD_PUSH: begin
                  if (stat.full) begin
                     ctrl.set_status = 1'b1;
                     ctrl.status     = ial_pkg::ST_FULL;
                  end else begin
                     ctrl.ptr_load = 1'b1;
                     ctrl.ptr_sel  = ial_pkg::PTR_COUNT;
                  end
               end
               ial_pkg::CMD_POP: begin
                  if (stat.empty) begin
                     ctrl.set_status = 1'b1;
                     ctrl.status     = ial_pkg::ST_EMPTY;
                  end else begin
                     ctrl.ptr_load = 1'b1;
                     ctrl.ptr_sel  = ial_pkg::PTR_COUNT_M1;
                     ctrl.cnt_dec  = 1'b1;
                  end
               end
               ial_pkg::CMD_INSERT: begin
                  if (!stat.pos_ok) begin
                     ctrl.set_status = 1'b1;
                     ctrl.status     = ial_pkg::ST_RANGE;
                  end else if (stat.full) begin
                     ctrl.set_status = 1'b1;
                     ctrl.status     = ial_pkg::ST_FULL;
                  end else begin
                     ctrl.ptr_load = 1'b1;
                     ctrl.ptr_sel  = ial_pkg::PTR_COUNT;
                  end
               end
               ial_pkg::CMD_ERASE, ial_pkg::CMD_READ: begin
                  if (!stat.pos_ok) begin
                     ctrl.set_status = 1'b1;
                     ctrl.status     = ial_pkg::ST_RANGE;
                  end else begin
                     ctrl.ptr_load = 1'b1;
                     ctrl.ptr_sel  = ial_pkg::PTR_POS;
                  end
               end
               default: begin
                  ctrl.ptr_load = 1'b0;
               end
            endcase
         end
         ial_pkg::S_WRITE: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wd_sel  = ial_pkg::WD_VALUE;
            ctrl.cnt_inc = 1'b1;
         end
         ial_pkg::S_UP_RD: begin
            if (!stat.ptr_at_pos) begin
               ctrl.rd_en  = 1'b1;
               ctrl.ra_sel = ial_pkg::RA_PTR_M1;
            end
         end
         ial_pkg::S_UP_WR: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wd_sel  = ial_pkg::WD_READ;
            ctrl.ptr_dec = 1'b1;
         end
         ial_pkg::S_DN_RD: begin
            if (stat.ptr_at_tail) begin
               ctrl.cnt_dec = 1'b1;
            end else begin
               ctrl.rd_en  = 1'b1;
               ctrl.ra_sel = ial_pkg::RA_PTR_P1;
            end
         end
         ial_pkg::S_DN_WR: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wd_sel  = ial_pkg::WD_READ;
            ctrl.ptr_inc = 1'b1;
         end
         ial_pkg::S_RD: begin
            ctrl.rd_en  = 1'b1;
            ctrl.ra_sel = ial_pkg::RA_PTR;
         end
         ial_pkg::S_RD_CAP: begin
            ctrl.cap_read = 1'b1;
         end
         ial_pkg::S_FIRST: begin
            ctrl.rd_en  = 1'b1;
            ctrl.ra_sel = ial_pkg::RA_ZERO;
         end
         ial_pkg::S_LAST: begin
            ctrl.cap_first = 1'b1;
            ctrl.rd_en     = 1'b1;
            ctrl.ra_sel    = ial_pkg::RA_LAST;
         end
         ial_pkg::S_LAST_CAP: begin
            ctrl.cap_last = 1'b1;
         end
         ial_pkg::S_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

endmodule

### hw/rtl/ial_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_datapath: storage and result registers of the indexed array list
// Holds the entry memory, the fill count, the walking pointer used for
// shifts and the registered fields of the result beat.
// ----------------------------------------------------------------------------
module ial_datapath #(
   parameter int DEPTH = ial_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic        [ial_pkg::CMD_W-1:0]    req_cmd,
   input  logic        [ial_pkg::POS_W-1:0]    req_position,
   input  logic signed [ial_pkg::DATA_W-1:0]   req_value,
   input  ial_pkg::ctrl_type                   ctrl,
   output ial_pkg::stat_type                   stat,
   output logic signed [ial_pkg::DATA_W-1:0]   rsp_read_value,
   output logic        [ial_pkg::STATUS_W-1:0] rsp_status,
   output logic        [ial_pkg::COUNT_W-1:0]  rsp_count,
   output logic signed [ial_pkg::DATA_W-1:0]   rsp_first_value,
   output logic signed [ial_pkg::DATA_W-1:0]   rsp_last_value
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > ial_pkg::POS_W) ? CW : ial_pkg::POS_W;
   localparam int XW = (CW > ial_pkg::COUNT_W) ? CW : ial_pkg::COUNT_W;

   logic [ial_pkg::DATA_W-1:0] mem [DEPTH];

   logic [ial_pkg::CMD_W-1:0]    cmd_ff;
   logic [ial_pkg::POS_W-1:0]    pos_ff;
   logic [ial_pkg::DATA_W-1:0]   value_ff;
   logic [CW-1:0]                ptr_ff;
   logic [CW-1:0]                ptr_in;
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic [ial_pkg::DATA_W-1:0]   rdata_ff;
   logic [ial_pkg::DATA_W-1:0]   read_ff;
   logic [ial_pkg::STATUS_W-1:0] status_ff;
   logic [ial_pkg::DATA_W-1:0]   first_ff;
   logic [ial_pkg::DATA_W-1:0]   last_ff;

   logic [CW-1:0]              count_m1;
   logic [CW-1:0]              ptr_m1;
   logic [CW-1:0]              ptr_p1;
   logic [CW-1:0]              raddr_wide;
   logic [AW-1:0]              raddr;
   logic [ial_pkg::DATA_W-1:0] wdata;
   logic [PW-1:0]              pos_ext;
   logic [PW-1:0]              count_ext;
   logic [PW-1:0]              ptr_ext;
   logic [XW-1:0]              count_out;

   assign count_m1  = count_ff - CW'(1);
   assign ptr_m1    = ptr_ff - CW'(1);
   assign ptr_p1    = ptr_ff + CW'(1);
   assign pos_ext   = PW'(pos_ff);
   assign count_ext = PW'(count_ff);
   assign ptr_ext   = PW'(ptr_ff);

   assign stat.cmd         = cmd_ff;
   assign stat.full        = (count_ff == CW'(DEPTH));
   assign stat.empty       = (count_ff == '0);
   assign stat.pos_ok      = (pos_ext < count_ext);
   assign stat.ptr_at_pos  = (ptr_ext == pos_ext);
   assign stat.ptr_at_tail = (ptr_p1 == count_ff);

   always_comb begin
      case (ctrl.ra_sel)
         ial_pkg::RA_PTR:    raddr_wide = ptr_ff;
         ial_pkg::RA_PTR_M1: raddr_wide = ptr_m1;
         ial_pkg::RA_PTR_P1: raddr_wide = ptr_p1;
         ial_pkg::RA_ZERO:   raddr_wide = '0;
         ial_pkg::RA_LAST:   raddr_wide = count_m1;
         default:            raddr_wide = '0;
      endcase
   end

   assign raddr = raddr_wide[AW-1:0];
   assign wdata = (ctrl.wd_sel == ial_pkg::WD_READ) ? rdata_ff : value_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ptr_ff[AW-1:0]] <= wdata;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (ctrl.ptr_load) begin
         case (ctrl.ptr_sel)
            ial_pkg::PTR_COUNT:    ptr_in = count_ff;
            ial_pkg::PTR_COUNT_M1: ptr_in = count_m1;
            ial_pkg::PTR_POS:      ptr_in = CW'(pos_ext);
            default:               ptr_in = count_ff;
         endcase
      end else if (ctrl.ptr_inc) begin
         ptr_in = ptr_p1;
      end else if (ctrl.ptr_dec) begin
         ptr_in = ptr_m1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.cnt_dec) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (ctrl.load_req) begin
         cmd_ff   <= req_cmd;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (ctrl.clr_result) begin
         read_ff   <= '0;
         status_ff <= ial_pkg::ST_OK;
      end else begin
         if (ctrl.cap_read) begin
            read_ff <= rdata_ff;
         end
         if (ctrl.set_status) begin
            status_ff <= ctrl.status;
         end
      end
      if (ctrl.cap_first) begin
         first_ff <= rdata_ff;
      end
      if (ctrl.cap_last) begin
         last_ff <= rdata_ff;
      end
   end

   assign count_out       = XW'(count_ff);
   assign rsp_read_value  = read_ff;
   assign rsp_status      = status_ff;
   assign rsp_count       = count_out[ial_pkg::COUNT_W-1:0];
   assign rsp_first_value = (count_ff == '0) ? '0 : first_ff;
   assign rsp_last_value  = (count_ff == '0) ? '0 : last_ff;

endmodule

### hw/rtl/indexed_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_list: bounded ordered list of signed words with indexed
// insert and erase
// A command is taken on req_cmd, req_position and req_value at a clock edge
// where start is high and busy is low. Commands are push back, pop back,
// insert at an index, erase at an index and read at an index.
// Each command gives exactly one result beat, marked by rsp_valid for one
// cycle: the popped or read word, a status (ok, empty, index out of range,
// full), the count after the command, and the first and last entries.
// The entries sit in a single memory with one write and one registered read
// per cycle, so the memory port sets the latency. After decoding, push
// writes its word, pop and read read one entry, insert and erase move each
// shifted entry with a read and a write, and insert then writes its word;
// an error or an ignored code does no access. The first and last entries
// are then read and the beat is sent. busy stays high until the result
// beat has been sent; the next command may be taken in the cycle after it.
// A synchronous reset empties the list and returns the sequencer to idle;
// memory contents are not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module indexed_array_list #(
   parameter int DEPTH = ial_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [ial_pkg::CMD_W-1:0]    req_cmd,
   input  logic        [ial_pkg::POS_W-1:0]    req_position,
   input  logic signed [ial_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   output logic signed [ial_pkg::DATA_W-1:0]   rsp_read_value,
   output logic        [ial_pkg::STATUS_W-1:0] rsp_status,
   output logic        [ial_pkg::COUNT_W-1:0]  rsp_count,
   output logic signed [ial_pkg::DATA_W-1:0]   rsp_first_value,
   output logic signed [ial_pkg::DATA_W-1:0]   rsp_last_value
);

   ial_pkg::ctrl_type ctrl;
   ial_pkg::stat_type stat;

   ial_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   ial_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_value       (req_value),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .rsp_first_value (rsp_first_value),
      .rsp_last_value  (rsp_last_value)
   );

endmodule

### tb/tb_indexed_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_array_list: self-checking bench for the indexed array list
// A queue of commands opens with a short directed sequence that covers the
// empty list, the unused command codes, the word extremes, and indexes at
// and past the end. Random fill and drain phases follow, which move the
// list between empty, full and random levels. Each accepted command is run
// through a behavioral list model. Every result beat is then checked field
// by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_indexed_array_list;

   localparam int LIST_DEPTH     = ial_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_CMDS    = 1150;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 20;

   localparam logic [ial_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd5;
   localparam logic [ial_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd6;
   localparam logic [ial_pkg::CMD_W-1:0] CMD_UNUSED_C = 3'd7;

   typedef struct {
      logic        [ial_pkg::CMD_W-1:0]  cmd;
      logic        [ial_pkg::POS_W-1:0]  position;
      logic signed [ial_pkg::DATA_W-1:0] value;
   } list_cmd_type;

   typedef struct {
      logic signed [ial_pkg::DATA_W-1:0]   read_value;
      logic        [ial_pkg::STATUS_W-1:0] status;
      logic        [ial_pkg::COUNT_W-1:0]  count;
      logic signed [ial_pkg::DATA_W-1:0]   first_value;
      logic signed [ial_pkg::DATA_W-1:0]   last_value;
   } list_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic        [ial_pkg::CMD_W-1:0]    req_cmd = '0;
   logic        [ial_pkg::POS_W-1:0]    req_position = '0;
   logic signed [ial_pkg::DATA_W-1:0]   req_value = '0;
   logic                                rsp_valid;
   logic signed [ial_pkg::DATA_W-1:0]   rsp_read_value;
   logic        [ial_pkg::STATUS_W-1:0] rsp_status;
   logic        [ial_pkg::COUNT_W-1:0]  rsp_count;
   logic signed [ial_pkg::DATA_W-1:0]   rsp_first_value;
   logic signed [ial_pkg::DATA_W-1:0]   rsp_last_value;

   list_cmd_type    list_cmds[$];
   list_result_type expected_results[$];

   logic signed [ial_pkg::DATA_W-1:0] model_words[LIST_DEPTH];
   int model_fill = 0;
   int planned_fill = 0;
   int useful_cmds = 0;
   int cmds_total = 0;
   int cmds_accepted = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int hold_off = 0;
   bit no_idle = 1'b0;
   int status_tally[4] = '{0, 0, 0, 0};
   int times_full = 0;
   int times_emptied = 0;
   list_cmd_type drive_item;

   indexed_array_list #(
      .DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_first_value(rsp_first_value),
      .rsp_last_value (rsp_last_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Behavioral list: applies one command and returns the result it causes.
   task automatic list_model_apply(input list_cmd_type c, output list_result_type r);
      int i;
      int pos;
      pos = int'(c.position);
      r.read_value = '0;
      r.status = ial_pkg::ST_OK;
      case (c.cmd)
         ial_pkg::CMD_PUSH: begin
            if (model_fill >= LIST_DEPTH) begin
               r.status = ial_pkg::ST_FULL;
            end else begin
               model_words[model_fill] = c.value;
               model_fill++;
               if (model_fill == LIST_DEPTH) times_full++;
            end
         end
         ial_pkg::CMD_POP: begin
            if (model_fill == 0) begin
               r.status = ial_pkg::ST_EMPTY;
            end else begin
               model_fill--;
               r.read_value = model_words[model_fill];
               if (model_fill == 0) times_emptied++;
            end
         end
         ial_pkg::CMD_INSERT: begin
            if (pos >= model_fill) begin
               r.status = ial_pkg::ST_RANGE;
            end else if (model_fill >= LIST_DEPTH) begin
               r.status = ial_pkg::ST_FULL;
            end else begin
               for (i = model_fill; i > pos; i--) model_words[i] = model_words[i-1];
               model_words[pos] = c.value;
               model_fill++;
               if (model_fill == LIST_DEPTH) times_full++;
            end
         end
         ial_pkg::CMD_ERASE: begin
            if (pos >= model_fill) begin
               r.status = ial_pkg::ST_RANGE;
            end else begin
               for (i = pos; i + 1 < model_fill; i++) model_words[i] = model_words[i+1];
               model_fill--;
               if (model_fill == 0) times_emptied++;
            end
         end
         ial_pkg::CMD_READ: begin
            if (pos >= model_fill) r.status = ial_pkg::ST_RANGE;
            else r.read_value = model_words[pos];
         end
         default: begin
         end
      endcase
      r.count = ial_pkg::COUNT_W'(model_fill);
      r.first_value = (model_fill == 0) ? '0 : model_words[0];
      r.last_value = (model_fill == 0) ? '0 : model_words[model_fill-1];
      status_tally[r.status]++;
   endtask

   task automatic add_cmd(input logic [ial_pkg::CMD_W-1:0] cmd,
                          input logic [ial_pkg::POS_W-1:0] pos,
                          input logic [ial_pkg::DATA_W-1:0] value);
      list_cmd_type c;
      c.cmd = cmd;
      c.position = pos;
      c.value = value;
      list_cmds.insert(list_cmds.size(), c);
      case (cmd)
         ial_pkg::CMD_PUSH: begin
            if (planned_fill < LIST_DEPTH) planned_fill++;
         end
         ial_pkg::CMD_POP: begin
            if (planned_fill > 0) planned_fill--;
         end
         ial_pkg::CMD_INSERT: begin
            if (int'(pos) < planned_fill && planned_fill < LIST_DEPTH) planned_fill++;
         end
         ial_pkg::CMD_ERASE: begin
            if (int'(pos) < planned_fill) planned_fill--;
         end
         default: begin
         end
      endcase
      if (cmd <= ial_pkg::CMD_READ) useful_cmds++;
   endtask

   function automatic logic [ial_pkg::POS_W-1:0] pick_position(input bit in_range);
      if (in_range && planned_fill > 0)
         return ial_pkg::POS_W'($urandom_range(0, planned_fill - 1));
      if (planned_fill < (1 << ial_pkg::POS_W))
         return ial_pkg::POS_W'($urandom_range(planned_fill, 63));
      return ial_pkg::POS_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [ial_pkg::DATA_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ial_pkg::CMD_W-1:0] pick_unused();
      case ($urandom_range(0, 2))
         0: return CMD_UNUSED_A;
         1: return CMD_UNUSED_B;
         default: return CMD_UNUSED_C;
      endcase
   endfunction

   task automatic add_random_cmd();
      int r;
      logic [ial_pkg::CMD_W-1:0] cmd;
      r = $urandom_range(0, 19);
      if (r < 4) cmd = ial_pkg::CMD_PUSH;
      else if (r < 7) cmd = ial_pkg::CMD_POP;
      else if (r < 11) cmd = ial_pkg::CMD_INSERT;
      else if (r < 14) cmd = ial_pkg::CMD_ERASE;
      else if (r < 18) cmd = ial_pkg::CMD_READ;
      else cmd = pick_unused();
      add_cmd(cmd, pick_position($urandom_range(0, 4) != 0), pick_word());
   endtask

   initial begin
      int target;
      add_cmd(ial_pkg::CMD_POP, 6'd0, 32'h0);
      add_cmd(ial_pkg::CMD_READ, 6'd0, 32'h0);
      add_cmd(ial_pkg::CMD_ERASE, 6'd0, 32'h0);
      add_cmd(ial_pkg::CMD_INSERT, 6'd0, 32'h1234_5678);
      add_cmd(CMD_UNUSED_A, 6'd63, 32'hFFFF_FFFF);
      add_cmd(CMD_UNUSED_B, 6'd42, 32'h5555_5555);
      add_cmd(CMD_UNUSED_C, 6'd21, 32'hAAAA_AAAA);
      add_cmd(ial_pkg::CMD_PUSH, 6'd0, 32'h7FFF_FFFF);
      add_cmd(ial_pkg::CMD_PUSH, 6'd63, 32'h8000_0000);
      add_cmd(ial_pkg::CMD_PUSH, 6'd0, 32'h0000_0000);
      add_cmd(ial_pkg::CMD_PUSH, 6'd0, 32'hFFFF_FFFF);
      add_cmd(ial_pkg::CMD_INSERT, 6'd0, 32'h5A5A_5A5A);
      add_cmd(ial_pkg::CMD_INSERT, 6'd4, 32'hA5A5_A5A5);
      add_cmd(ial_pkg::CMD_INSERT, 6'd6, 32'h0F0F_0F0F);
      add_cmd(ial_pkg::CMD_READ, 6'd0, 32'h0);
      add_cmd(ial_pkg::CMD_READ, 6'd5, 32'h0);
      add_cmd(ial_pkg::CMD_READ, 6'd63, 32'h0);
      add_cmd(ial_pkg::CMD_ERASE, 6'd0, 32'h0);
      add_cmd(ial_pkg::CMD_ERASE, 6'd4, 32'h0);
      add_cmd(ial_pkg::CMD_ERASE, 6'd4, 32'h0);
      repeat (5) add_cmd(ial_pkg::CMD_POP, 6'd0, 32'h0);

      useful_cmds = 0;
      while (useful_cmds < RANDOM_CMDS) begin
         case ($urandom_range(0, 2))
            0: target = LIST_DEPTH;
            1: target = 0;
            default: target = $urandom_range(0, LIST_DEPTH);
         endcase
         while (planned_fill != target && useful_cmds < RANDOM_CMDS) begin
            if ($urandom_range(0, 9) == 0) begin
               add_random_cmd();
            end else if (planned_fill < target) begin
               if (planned_fill > 0 && $urandom_range(0, 1) == 1)
                  add_cmd(ial_pkg::CMD_INSERT, pick_position(1'b1), pick_word());
               else
                  add_cmd(ial_pkg::CMD_PUSH, ial_pkg::POS_W'($urandom), pick_word());
            end else begin
               if ($urandom_range(0, 1) == 1)
                  add_cmd(ial_pkg::CMD_ERASE, pick_position(1'b1), pick_word());
               else
                  add_cmd(ial_pkg::CMD_POP, ial_pkg::POS_W'($urandom), pick_word());
            end
         end
         if (planned_fill == LIST_DEPTH) begin
            add_cmd(ial_pkg::CMD_PUSH, ial_pkg::POS_W'($urandom), pick_word());
            add_cmd(ial_pkg::CMD_INSERT, 6'd63, pick_word());
            add_cmd(ial_pkg::CMD_ERASE, 6'd63, pick_word());
         end else if (planned_fill == 0) begin
            add_cmd(ial_pkg::CMD_POP, ial_pkg::POS_W'($urandom), pick_word());
            add_cmd(ial_pkg::CMD_INSERT, pick_position(1'b0), pick_word());
         end
         repeat ($urandom_range(1, 6)) add_random_cmd();
      end
      cmds_total = list_cmds.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (cmds_accepted < cmds_total || expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d commands: %0d ok, %0d empty, %0d out of range, %0d full.",
               cmds_accepted, status_tally[ial_pkg::ST_OK], status_tally[ial_pkg::ST_EMPTY],
               status_tally[ial_pkg::ST_RANGE], status_tally[ial_pkg::ST_FULL]);
      $display("The list was filled %0d times and emptied %0d times.",
               times_full, times_emptied);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Command driver. A beat is taken at an edge where start is high and busy low.
   always @(posedge clock) begin
      list_result_type predicted;
      if (reset) begin
         start <= 1'b0;
         hold_off = 0;
      end else begin
         if (start && !busy) begin
            list_model_apply(drive_item, predicted);
            expected_results.insert(expected_results.size(), predicted);
            cmds_accepted++;
         end
         if (!start || !busy) begin
            if (hold_off > 0) begin
               hold_off--;
               start <= 1'b0;
            end else if (list_cmds.size() > 0) begin
               drive_item = list_cmds.pop_front();
               req_cmd <= drive_item.cmd;
               req_position <= drive_item.position;
               req_value <= drive_item.value;
               start <= 1'b1;
               if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
               hold_off = no_idle ? 0 : $urandom_range(0, 16);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result beat arrived with no command outstanding");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               mismatch_count++;
            end
            if (rsp_first_value !== want.first_value) begin
               $error("first_value: expected %0d, got %0d", want.first_value, rsp_first_value);
               mismatch_count++;
            end
            if (rsp_last_value !== want.last_value) begin
               $error("last_value: expected %0d, got %0d", want.last_value, rsp_last_value);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
